// ----- rtl/mpbd_pkg.sv -----
// shared types and constants of the mip pyramid downsampler
// no dependencies
package mpbd_pkg;

  localparam int DEF_MAX_SIDE    = 8192;
  localparam int DEF_LEVEL_COUNT = 13;

  localparam int PIX_W       = 8;
  localparam int POS_W       = 13;
  localparam int LEVEL_W     = 4;
  localparam int SIDE_CFG_W  = 14;
  localparam int SKIP_W      = 4;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_INDEX_W = 2;
  localparam int OUT_DEPTH   = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SKIPPED_LEVELS = 2'd2;

  localparam logic [SIDE_CFG_W-1:0] RST_IMAGE_WIDTH  = 14'd8192;
  localparam logic [SIDE_CFG_W-1:0] RST_IMAGE_HEIGHT = 14'd4096;

  // one result as produced by a cell, final marks the end of its input's run
  typedef struct packed {
    logic               valid;
    logic               final_res;
    logic [LEVEL_W-1:0] level;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [PIX_W-1:0]   value;
  } emit_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [PIX_W-1:0]   value;
    logic               last;
  } res_t;

endpackage

// ----- rtl/mip_pyramid_box_downsampler.sv -----
// mip pyramid downsampler: a chain of one cell per level behind the level-0 cell
// results: a level-k result comes from the token registered in each of cells 1 to k,
//   then waits in the held result register and enters the output fifo
// input: a pixel holds the chain while its token moves down the cells; the next one
//   enters once the current one ends at a level with no result and the fifo has room
// reset: counters, held pixels and the output fifo clear; row memories are not cleared
// depends on mpbd_pkg, mpbd_source, mpbd_cell, mpbd_out
module mip_pyramid_box_downsampler #(
  parameter int MAX_SIDE    = mpbd_pkg::DEF_MAX_SIDE,
  parameter int LEVEL_COUNT = mpbd_pkg::DEF_LEVEL_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mpbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mpbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mpbd_pkg::PIX_W-1:0]       height_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mpbd_pkg::LEVEL_W-1:0]     level,
  output logic [mpbd_pkg::POS_W-1:0]       out_x,
  output logic [mpbd_pkg::POS_W-1:0]       out_y,
  output logic [mpbd_pkg::PIX_W-1:0]       pixel_value,
  output logic                             last_of_run
);
  import mpbd_pkg::*;

  localparam int XW  = $clog2(MAX_SIDE);
  localparam int SDW = $clog2(MAX_SIDE + 1);

  logic [SIDE_CFG_W-1:0] image_width;
  logic [SIDE_CFG_W-1:0] image_height;
  logic [SKIP_W-1:0]     skipped_levels;
  logic                  clear;

  logic [SDW-1:0] side_w [LEVEL_COUNT + 1];
  logic [SDW-1:0] side_h [LEVEL_COUNT + 1];

  logic             pass_valid [LEVEL_COUNT + 1];
  logic [PIX_W-1:0] pass_p     [LEVEL_COUNT + 1];
  logic [XW-1:0]    pass_x     [LEVEL_COUNT + 1];
  logic [XW-1:0]    pass_y     [LEVEL_COUNT + 1];
  logic [XW-1:0]    col        [LEVEL_COUNT + 1];
  emit_t            em         [LEVEL_COUNT + 1];
  logic             active     [LEVEL_COUNT + 1];
  logic             src_silent;

  emit_t emit;
  logic  silent;
  logic  chain_busy;
  logic  go;
  logic  accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      skipped_levels <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    image_width    <= SIDE_CFG_W'(cfg_data);
        REG_IMAGE_HEIGHT:   image_height   <= SIDE_CFG_W'(cfg_data);
        REG_SKIPPED_LEVELS: skipped_levels <= SKIP_W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign clear = cfg_write && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT ||
                               cfg_index == REG_SKIPPED_LEVELS);

  // level sides: clamp level 0, then halve with a floor of one
  always_comb begin
    if (image_width == '0) side_w[0] = SDW'(1);
    else if (32'(image_width) > MAX_SIDE) side_w[0] = SDW'(MAX_SIDE);
    else side_w[0] = SDW'(image_width);
    if (image_height == '0) side_h[0] = SDW'(1);
    else if (32'(image_height) > MAX_SIDE) side_h[0] = SDW'(MAX_SIDE);
    else side_h[0] = SDW'(image_height);
    for (int k = 1; k <= LEVEL_COUNT; k++) begin
      side_w[k] = ((side_w[0] >> k) == '0) ? SDW'(1) : (side_w[0] >> k);
      side_h[k] = ((side_h[0] >> k) == '0) ? SDW'(1) : (side_h[0] >> k);
    end
  end

  mpbd_source #(
    .XW       (XW),
    .SDW      (SDW)
  ) u_source (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .clear      (clear),
    .sample     (height_sample),
    .w          (side_w[0]),
    .h          (side_h[0]),
    .skip       (skipped_levels),
    .pass_valid (pass_valid[0]),
    .pass_p     (pass_p[0]),
    .pass_x     (pass_x[0]),
    .pass_y     (pass_y[0]),
    .col        (col[0]),
    .em         (em[0]),
    .silent     (src_silent)
  );
  assign active[0] = accept;

  for (genvar k = 1; k <= LEVEL_COUNT; k++) begin : g_cell
    mpbd_cell #(
      .LEVEL       (k),
      .MAX_SIDE    (MAX_SIDE),
      .LEVEL_COUNT (LEVEL_COUNT),
      .XW          (XW),
      .SDW         (SDW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .go           (go),
      .clear        (clear),
      .tok_in_valid (pass_valid[k-1]),
      .tok_in_p     (pass_p[k-1]),
      .tok_in_x     (pass_x[k-1]),
      .tok_in_y     (pass_y[k-1]),
      .prev_col     (col[k-1]),
      .src_w        (side_w[k-1]),
      .src_h        (side_h[k-1]),
      .w            (side_w[k]),
      .h            (side_h[k]),
      .skip         (skipped_levels),
      .active       (active[k]),
      .pass_valid   (pass_valid[k]),
      .pass_p       (pass_p[k]),
      .pass_x       (pass_x[k]),
      .pass_y       (pass_y[k]),
      .col          (col[k]),
      .em           (em[k])
    );
  end

  // only one pixel is at work in the cells, so their results merge by or
  always_comb begin
    emit       = em[0];
    silent     = src_silent;
    chain_busy = 1'b0;
    for (int k = 1; k <= LEVEL_COUNT; k++) begin
      emit       = emit | em[k];
      silent     = silent | (active[k] && !pass_valid[k] && !em[k].valid);
      chain_busy = chain_busy | pass_valid[k] | em[k].valid;
    end
  end

  assign in_stall = !go || chain_busy;
  assign accept   = in_valid && !in_stall;

  mpbd_out u_out (
    .clk         (clk),
    .rst         (rst),
    .emit        (emit),
    .silent      (silent),
    .go          (go),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .level       (level),
    .out_x       (out_x),
    .out_y       (out_y),
    .pixel_value (pixel_value),
    .last_of_run (last_of_run)
  );

endmodule

// ----- rtl/mpbd_source.sv -----
// level-0 cell: position counters of the full-size image
// depends on mpbd_pkg
module mpbd_source #(
  parameter int XW       = 13,
  parameter int SDW      = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       clear,
  input  logic [mpbd_pkg::PIX_W-1:0] sample,
  input  logic [SDW-1:0]             w,
  input  logic [SDW-1:0]             h,
  input  logic [mpbd_pkg::SKIP_W-1:0] skip,
  output logic                       pass_valid,
  output logic [mpbd_pkg::PIX_W-1:0] pass_p,
  output logic [XW-1:0]              pass_x,
  output logic [XW-1:0]              pass_y,
  output logic [XW-1:0]              col,
  output mpbd_pkg::emit_t            em,
  output logic                       silent
);
  import mpbd_pkg::*;

  logic [XW-1:0] row;
  logic          col_wrap;
  logic          row_wrap;

  assign col_wrap = (SDW + 1)'(col) + (SDW + 1)'(1) >= (SDW + 1)'(w);
  assign row_wrap = (SDW + 1)'(row) + (SDW + 1)'(1) >= (SDW + 1)'(h);

  always_comb begin
    pass_valid = accept && !(w == SDW'(1) && h == SDW'(1));
    pass_p     = sample;
    pass_x     = col;
    pass_y     = row;
    em         = '0;
    if (accept && skip == '0) begin
      em.valid     = 1'b1;
      em.final_res = !pass_valid;
      em.level     = '0;
      em.x         = POS_W'(col);
      em.y         = POS_W'(row);
      em.value     = sample;
    end
    silent = accept && !pass_valid && !em.valid;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + XW'(1);
      end else begin
        col <= col + XW'(1);
      end
    end
  end

endmodule

// ----- rtl/mpbd_cell.sv -----
// one pyramid level: column pair, row pair memory and position counters
// depends on mpbd_pkg
module mpbd_cell #(
  parameter int LEVEL       = 1,
  parameter int MAX_SIDE    = mpbd_pkg::DEF_MAX_SIDE,
  parameter int LEVEL_COUNT = mpbd_pkg::DEF_LEVEL_COUNT,
  parameter int XW          = 13,
  parameter int SDW         = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic                        clear,
  input  logic                        tok_in_valid,
  input  logic [mpbd_pkg::PIX_W-1:0]  tok_in_p,
  input  logic [XW-1:0]               tok_in_x,
  input  logic [XW-1:0]               tok_in_y,
  input  logic [XW-1:0]               prev_col,
  input  logic [SDW-1:0]              src_w,
  input  logic [SDW-1:0]              src_h,
  input  logic [SDW-1:0]              w,
  input  logic [SDW-1:0]              h,
  input  logic [mpbd_pkg::SKIP_W-1:0] skip,
  output logic                        active,
  output logic                        pass_valid,
  output logic [mpbd_pkg::PIX_W-1:0]  pass_p,
  output logic [XW-1:0]               pass_x,
  output logic [XW-1:0]               pass_y,
  output logic [XW-1:0]               col,
  output mpbd_pkg::emit_t             em
);
  import mpbd_pkg::*;

  localparam int DEPTH = ((MAX_SIDE >> LEVEL) > 0) ? (MAX_SIDE >> LEVEL) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             tok_valid;
  logic [PIX_W-1:0] tok_p;
  logic [XW-1:0]    tok_x;
  logic [XW-1:0]    tok_y;
  logic [XW-1:0]    row;
  logic [PIX_W-1:0] held;
  logic [8:0]       mem [DEPTH];
  logic [8:0]       rdata;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;

  logic             drop;
  logic             have_h;
  logic             produced;
  logic             hold_left;
  logic             write_row;
  logic [8:0]       hsum;
  logic [9:0]       total;
  logic [PIX_W-1:0] value;
  logic             col_wrap;
  logic             row_wrap;

  // the upper row of a pair is read while the token sits one cell back
  assign raddr  = AW'(prev_col >> 1);
  assign waddr  = AW'(tok_x >> 1);
  assign active = tok_valid;

  assign col_wrap = (SDW + 1)'(col) + (SDW + 1)'(1) >= (SDW + 1)'(w);
  assign row_wrap = (SDW + 1)'(row) + (SDW + 1)'(1) >= (SDW + 1)'(h);

  always_comb begin
    drop      = ((SDW + 1)'(tok_x) >= {w, 1'b0}) || ((SDW + 1)'(tok_y) >= {h, 1'b0});
    hsum      = '0;
    total     = '0;
    have_h    = 1'b0;
    produced  = 1'b0;
    hold_left = 1'b0;
    write_row = 1'b0;
    if (tok_valid && !drop) begin
      if (src_w == SDW'(1)) begin
        hsum   = {tok_p, 1'b0};
        have_h = 1'b1;
      end else if (!tok_x[0]) begin
        hold_left = 1'b1;
      end else begin
        hsum   = 9'(held) + 9'(tok_p);
        have_h = 1'b1;
      end
      if (have_h) begin
        if (src_h == SDW'(1)) begin
          total    = {hsum, 1'b0};
          produced = 1'b1;
        end else if (!tok_y[0]) begin
          write_row = 1'b1;
        end else begin
          total    = 10'(hsum) + 10'(rdata);
          produced = 1'b1;
        end
      end
    end
    value = PIX_W'((total + 10'd2) >> 2);

    pass_valid = produced && (LEVEL < LEVEL_COUNT) && !(w == SDW'(1) && h == SDW'(1));
    pass_p     = value;
    pass_x     = col;
    pass_y     = row;

    em = '0;
    if (produced && (5'(LEVEL) >= {1'b0, skip})) begin
      em.valid     = 1'b1;
      em.final_res = !pass_valid;
      em.level     = LEVEL_W'(LEVEL);
      em.x         = POS_W'(col);
      em.y         = POS_W'(row);
      em.value     = value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (go) begin
      tok_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      tok_p <= tok_in_p;
      tok_x <= tok_in_x;
      tok_y <= tok_in_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (go && hold_left) begin
      held <= tok_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col <= '0;
      row <= '0;
    end else if (go && produced) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + XW'(1);
      end else begin
        col <= col + XW'(1);
      end
    end
  end

  // row pair memory, write-through on a same-address read
  always_ff @(posedge clk) begin
    if (go) begin
      if (write_row) begin
        mem[waddr] <= hsum;
      end
      rdata <= (write_row && waddr == raddr) ? hsum : mem[raddr];
    end
  end

endmodule

// ----- rtl/mpbd_out.sv -----
// result ordering: one held result to mark the end of a run, then a small fifo
// depends on mpbd_pkg
module mpbd_out (
  input  logic                         clk,
  input  logic                         rst,
  input  mpbd_pkg::emit_t              emit,
  input  logic                         silent,
  output logic                         go,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mpbd_pkg::LEVEL_W-1:0] level,
  output logic [mpbd_pkg::POS_W-1:0]   out_x,
  output logic [mpbd_pkg::POS_W-1:0]   out_y,
  output logic [mpbd_pkg::PIX_W-1:0]   pixel_value,
  output logic                         last_of_run
);
  import mpbd_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);

  emit_t         hold;
  res_t          fifo [OUT_DEPTH];
  res_t          head;
  res_t          push_res;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign go   = count != (PW + 1)'(OUT_DEPTH);
  assign push = go && hold.valid && (hold.final_res || emit.valid);
  assign pop  = out_valid && !out_stall;

  always_comb begin
    push_res.level = hold.level;
    push_res.x     = hold.x;
    push_res.y     = hold.y;
    push_res.value = hold.value;
    push_res.last  = hold.final_res || silent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold.valid     <= 1'b0;
      hold.final_res <= 1'b0;
    end else if (go) begin
      if (emit.valid) begin
        hold <= emit;
      end else if (push) begin
        hold.valid <= 1'b0;
      end else if (silent) begin
        // run ended at a level with no result, the held one is its last
        hold.final_res <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end

  assign head        = fifo[rd_ptr];
  assign out_valid   = count != '0;
  assign level       = head.level;
  assign out_x       = head.x;
  assign out_y       = head.y;
  assign pixel_value = head.value;
  assign last_of_run = head.last;

endmodule

// ----- rtl/mpbd_checker.sv -----
// port-level checks of the mip pyramid downsampler, bound to the top level
// depends on mpbd_pkg and mip_pyramid_box_downsampler
module mpbd_port_checks #(
  parameter int LEVEL_COUNT = mpbd_pkg::DEF_LEVEL_COUNT
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [mpbd_pkg::LEVEL_W-1:0] level,
  input logic [mpbd_pkg::POS_W-1:0]   out_x,
  input logic [mpbd_pkg::POS_W-1:0]   out_y,
  input logic [mpbd_pkg::PIX_W-1:0]   pixel_value,
  input logic                         last_of_run
);
  import mpbd_pkg::*;

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(level) <= LEVEL_COUNT)
    else $error("result level beyond the pyramid");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({level, out_x, out_y, pixel_value, last_of_run}))
    else $error("stalled result changed");

endmodule

bind mip_pyramid_box_downsampler mpbd_port_checks #(.LEVEL_COUNT(LEVEL_COUNT)) u_mpbd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .level       (level),
  .out_x       (out_x),
  .out_y       (out_y),
  .pixel_value (pixel_value),
  .last_of_run (last_of_run)
);

// ----- tb/mpbd_checker.sv -----
// result checker for the mip pyramid downsampler: tracks register writes,
// predicts unskipped levels' pixels from accepted inputs and compares them in order
// depends on mpbd_pkg
module mpbd_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mpbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mpbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [mpbd_pkg::PIX_W-1:0]       height_sample,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [mpbd_pkg::LEVEL_W-1:0]     level,
  input  logic [mpbd_pkg::POS_W-1:0]       out_x,
  input  logic [mpbd_pkg::POS_W-1:0]       out_y,
  input  logic [mpbd_pkg::PIX_W-1:0]       pixel_value,
  input  logic                             last_of_run,
  output int                               errors,
  output int                               pending,
  output int                               pixels_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import mpbd_pkg::*;

  localparam int MAX_SIDE = DEF_MAX_SIDE;
  localparam int NLEV     = DEF_LEVEL_COUNT + 1;

  logic [SIDE_CFG_W-1:0] width_reg, height_reg;
  logic [SKIP_W-1:0]     skip_reg;
  logic [8:0]            pair_sum [MAX_SIDE];
  logic [PIX_W-1:0]      left_pix [NLEV-1];
  int unsigned           col_pos [NLEV];
  int unsigned           row_pos [NLEV];
  res_t                  pyramid_q [$];

  function automatic int unsigned clamp_side(logic [SIDE_CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  task automatic clear_positions();
    for (int k = 0; k < NLEV; k++) begin
      col_pos[k] = 0;
      row_pos[k] = 0;
    end
  endtask

  task automatic advance(int k, int unsigned w, int unsigned h,
                         output int unsigned x, output int unsigned y);
    x = col_pos[k];
    y = row_pos[k];
    if (col_pos[k] + 1 >= w) begin
      col_pos[k] = 0;
      row_pos[k] = (row_pos[k] + 1 >= h) ? 0 : row_pos[k] + 1;
    end else begin
      col_pos[k]++;
    end
  endtask

  // cascade one level-0 pixel down the pyramid and queue what it produces
  task automatic predict_pyramid(logic [PIX_W-1:0] sample);
    int unsigned wd [NLEV], ht [NLEV], off [NLEV];
    int unsigned x, y, p, hsum, total, idx;
    int levels;
    res_t r;
    res_t run [$];
    wd[0] = clamp_side(width_reg);
    ht[0] = clamp_side(height_reg);
    off[0] = 0;
    levels = 1;
    while (levels < NLEV && !(wd[levels-1] == 1 && ht[levels-1] == 1)) begin
      wd[levels] = (wd[levels-1] / 2 != 0) ? wd[levels-1] / 2 : 1;
      ht[levels] = (ht[levels-1] / 2 != 0) ? ht[levels-1] / 2 : 1;
      off[levels] = (levels == 1) ? 0 : off[levels-1] + wd[levels-1];
      levels++;
    end
    p = sample;
    advance(0, wd[0], ht[0], x, y);
    if (skip_reg == 0) begin
      r = '{level: '0, x: POS_W'(x), y: POS_W'(y), value: PIX_W'(p), last: 1'b0};
      run.push_back(r);
    end
    for (int k = 1; k < levels; k++) begin
      // odd trailing row or column has no partner
      if (x >= 2 * wd[k] || y >= 2 * ht[k]) break;
      if (wd[k-1] == 1) begin
        hsum = 2 * p;
      end else if (x[0] == 1'b0) begin
        left_pix[k-1] = PIX_W'(p);
        break;
      end else begin
        hsum = left_pix[k-1] + p;
      end
      idx = off[k] + (x >> 1);
      if (ht[k-1] == 1) begin
        total = 2 * hsum;
      end else if (y[0] == 1'b0) begin
        if (idx < MAX_SIDE) pair_sum[idx] = hsum[8:0];
        break;
      end else begin
        total = hsum + ((idx < MAX_SIDE) ? pair_sum[idx] : 0);
      end
      p = (total + 2) >> 2;
      advance(k, wd[k], ht[k], x, y);
      if (k >= skip_reg) begin
        r = '{level: LEVEL_W'(k), x: POS_W'(x), y: POS_W'(y), value: PIX_W'(p),
              last: 1'b0};
        run.push_back(r);
      end
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) pyramid_q.push_back(run[i]);
  endtask

  always @(posedge clk) begin
    res_t exp_r;
    if (rst) begin
      width_reg  = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      skip_reg   = '0;
      for (int k = 0; k < NLEV - 1; k++) left_pix[k] = '0;
      clear_positions();
      pyramid_q.delete();
      errors = 0;
      pixels_checked = 0;
      pending = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_reg = cfg_data;
            clear_positions();
          end
          REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data;
            clear_positions();
          end
          REG_SKIPPED_LEVELS: begin
            skip_reg = cfg_data[SKIP_W-1:0];
            clear_positions();
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        pixels_checked++;
        if (pyramid_q.size() == 0) begin
          errors++;
          $display("%t unexpected transfer: level %0d x %0d y %0d value %0d", $time,
                   level, out_x, out_y, pixel_value);
        end else begin
          exp_r = pyramid_q.pop_front();
          if (level !== exp_r.level) begin
            errors++;
            $display("%t level: expected %0d actual %0d", $time, exp_r.level, level);
          end
          if (out_x !== exp_r.x) begin
            errors++;
            $display("%t out_x: expected %0d actual %0d", $time, exp_r.x, out_x);
          end
          if (out_y !== exp_r.y) begin
            errors++;
            $display("%t out_y: expected %0d actual %0d", $time, exp_r.y, out_y);
          end
          if (pixel_value !== exp_r.value) begin
            errors++;
            $display("%t pixel_value: expected %0d actual %0d", $time, exp_r.value,
                     pixel_value);
          end
          if (last_of_run !== exp_r.last) begin
            errors++;
            $display("%t last_of_run: expected %0b actual %0b", $time, exp_r.last,
                     last_of_run);
          end
        end
      end
      if (in_valid && !in_stall) predict_pyramid(height_sample);
      pending = pyramid_q.size();
    end
  end

endmodule

// ----- tb/tb_mip_pyramid_box_downsampler.sv -----
// top of the mip pyramid downsampler testbench: clock, reset, register
// writes and pixel stimulus; checking lives in mpbd_checker
// depends on mpbd_pkg, mpbd_checker and the block's rtl
module tb_mip_pyramid_box_downsampler;
  timeunit 1ns;
  timeprecision 1ps;
  import mpbd_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  // index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [PIX_W-1:0]       height_sample;
  logic                   out_valid;
  logic                   out_stall;
  logic [LEVEL_W-1:0]     level;
  logic [POS_W-1:0]       out_x;
  logic [POS_W-1:0]       out_y;
  logic [PIX_W-1:0]       pixel_value;
  logic                   last_of_run;
  int                     errors, pending, pixels_checked;
  int                     burst_left;
  int                     pixels_sent;
  int                     frames_set;

  always #5 clk = ~clk;

  mip_pyramid_box_downsampler u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .height_sample(height_sample),
    .out_valid(out_valid), .out_stall(out_stall), .level(level),
    .out_x(out_x), .out_y(out_y), .pixel_value(pixel_value),
    .last_of_run(last_of_run)
  );

  mpbd_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .height_sample(height_sample),
    .out_valid(out_valid), .out_stall(out_stall), .level(level),
    .out_x(out_x), .out_y(out_y), .pixel_value(pixel_value),
    .last_of_run(last_of_run),
    .errors(errors), .pending(pending), .pixels_checked(pixels_checked)
  );

  // receiver stall pattern: modes switch between free, light and heavy stalls
  int stall_mode, stall_left;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // wait until the pyramid has fully drained before touching registers
  task automatic wait_idle();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                           logic [SKIP_W-1:0] skip, bit stray_write);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_SKIPPED_LEVELS;
    cfg_data  <= {{(CFG_DATA_W-SKIP_W){1'b0}}, skip};
    @(posedge clk);
    if (stray_write) begin
      // index with no register behind it: nothing may change
      cfg_index <= REG_UNUSED;
      cfg_data  <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    frames_set++;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid      <= 1'b1;
    height_sample <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    pixels_sent++;
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_pixel(PIX_W'($urandom));
  endtask

  initial begin
    int w, h, n;
    rst = 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    height_sample <= '0;
    out_stall <= 1'b0;
    stall_left = 0;
    burst_left = 0;
    pixels_sent = 0;
    frames_set = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full-range extremes and round-half-up on a 3x3 frame with a dropped edge
    set_frame(3, 3, 0, 1'b1);
    send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd0);
    send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd0);
    send_pixel(8'd0);   send_pixel(8'd1);   send_pixel(8'd255);
    set_frame(2, 2, 0, 1'b0);
    send_pixel(8'd0); send_pixel(8'd1); send_pixel(8'd1); send_pixel(8'd0);
    // zero sides read as one, a side of one pixel duplicates down
    set_frame(0, 0, 0, 1'b0);
    send_pixel(8'd170);
    set_frame(1, 4, 1, 1'b0);
    send_pixel(8'd85); send_pixel(8'd255); send_pixel(8'd7); send_pixel(8'd200);
    // skip at and above the level count: nothing comes out
    set_frame(4, 4, 3, 1'b0);
    send_random(4);
    set_frame(5, 2, 15, 1'b0);
    send_random(3);

    // largest and oversized sides, partial frames only
    set_frame(16383, 1, 0, 1'b1);
    send_random(40);
    set_frame(1, 8192, 12, 1'b0);
    send_random(40);
    set_frame(8192, 16383, 0, 1'b0);
    send_random(20);
    set_frame(8193, 2, 13, 1'b0);
    send_random(20);

    // random small frames, mostly whole frames with random content
    while (pixels_sent < 470) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 12);
      set_frame(CFG_DATA_W'(w), CFG_DATA_W'(h),
                SKIP_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(0, 2)),
                $urandom_range(0, 7) == 0);
      n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      if (n > 60 || $urandom_range(0, 5) == 0) n = $urandom_range(1, 60);
      else if ($urandom_range(0, 2) == 0) n = 2 * n;
      send_random(n);
    end

    wait_idle();
    $display("pixels sent: %0d over %0d frame settings", pixels_sent, frames_set);
    $display("pyramid pixels checked: %0d, mismatches: %0d", pixels_checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
